>>> hw/rtl/pps_pkg.sv
`default_nettype none

package pps_pkg;

   // Field widths of the item formats
   localparam int unsigned SLOT_FIELD_W = 4;
   localparam int unsigned ARR_W        = 16;
   localparam int unsigned BURST_W      = 16;
   localparam int unsigned PRIO_W       = 8;
   localparam int unsigned TOUT_W       = 16;

   // Packed widths on the stream ports
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 40;

   // Item kinds carried in req_tuser
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // One process slot as kept in the slot memory
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] remaining;
      logic [PRIO_W-1:0]  prio;
   } slot_entry_type;

   // Input item after unpacking
   typedef struct packed {
      opcode_type                opcode;
      logic [SLOT_FIELD_W-1:0]   slot;
      logic [ARR_W-1:0]          arrival;
      logic [BURST_W-1:0]        burst;
      logic [PRIO_W-1:0]         prio;
   } req_item_type;

   // Result of one tick
   typedef struct packed {
      logic [TOUT_W-1:0]       time_after;
      logic [SLOT_FIELD_W-1:0] granted_slot;
      logic                    idle;
      logic [BURST_W-1:0]      left_after;
      logic                    finished;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> hw/rtl/pps_slot_mem.sv
`default_nettype none

module pps_slot_mem #(
   parameter int unsigned SLOTS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(SLOTS)-1:0]   rd_addr,
   output pps_pkg::slot_entry_type         rd_data,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(SLOTS)-1:0]   wr_addr,
   input  wire pps_pkg::slot_entry_type    wr_data
);
   import pps_pkg::*;

   slot_entry_type mem_ff [SLOTS];
   slot_entry_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pps_ctrl.sv
`default_nettype none

module pps_ctrl #(
   parameter int unsigned SLOTS     = 16,
   parameter int unsigned TIME_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input item side
   input  wire logic                  item_valid,
   output logic                       item_ready,
   input  wire pps_pkg::req_item_type item,
   // result side
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output pps_pkg::rsp_item_type      res
);
   import pps_pkg::*;

   localparam int unsigned SW = $clog2(SLOTS);
   localparam int unsigned CW = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_LAST = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [SW-1:0]        cnt_ff, cnt_in;
   logic                 cand_vld_ff, cand_vld_in;
   logic [SW-1:0]        cand_idx_ff, cand_idx_in;
   logic                 found_ff, found_in;
   logic [SW-1:0]        best_idx_ff, best_idx_in;
   slot_entry_type       best_ff, best_in;
   logic [SLOTS-1:0]     pend_ff, pend_in;
   logic [TIME_BITS-1:0] time_ff, time_in;

   logic                 rd_en;
   slot_entry_type       rd_data;
   logic                 wr_en;
   logic [SW-1:0]        wr_addr;
   slot_entry_type       wr_data;

   logic                 accept;
   logic                 load_hit;
   logic [SW-1:0]        load_idx;
   logic                 cand_take;
   logic [BURST_W-1:0]   rem_new;
   logic [TIME_BITS-1:0] time_next;
   logic                 finish;

   pps_slot_mem #(
      .SLOTS(SLOTS)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign item_ready = (state_ff == ST_IDLE);
   assign accept     = item_valid && item_ready;
   assign load_hit   = (int'(item.slot) < SLOTS);
   assign load_idx   = SW'(item.slot);

   // Candidate arriving from memory: pending, arrived, strictly better
   assign cand_take = cand_vld_ff && pend_ff[cand_idx_ff]
                      && (CW'(rd_data.arrival) <= CW'(time_ff))
                      && (!found_ff || (rd_data.prio > best_ff.prio));

   // Grant arithmetic for the winner
   assign rem_new   = (best_ff.remaining != '0) ? best_ff.remaining - 1'b1
                                                : best_ff.remaining;
   assign finish    = found_ff && (rem_new == '0);
   assign time_next = (time_ff == TIME_MAX) ? time_ff : time_ff + 1'b1;

   assign rd_en     = (state_ff == ST_SCAN);
   assign res_valid = (state_ff == ST_DONE);

   // Memory write: load in idle, write-back of the winner at the end
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = load_idx;
      wr_data = '{arrival: item.arrival, remaining: item.burst, prio: item.prio};
      if (accept && item.opcode == OP_LOAD && load_hit) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_DONE && res_ready && found_ff) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_data = '{arrival: best_ff.arrival, remaining: rem_new, prio: best_ff.prio};
      end
   end

   // Result fields
   always_comb begin
      res.time_after   = TOUT_W'(time_next);
      res.granted_slot = found_ff ? SLOT_FIELD_W'(best_idx_ff) : '0;
      res.idle         = !found_ff;
      res.left_after   = found_ff ? rem_new : '0;
      res.finished     = finish;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cand_vld_in = 1'b0;
      cand_idx_in = cnt_ff;
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      pend_in     = pend_ff;
      time_in     = time_ff;

      if (cand_take) begin
         found_in    = 1'b1;
         best_idx_in = cand_idx_ff;
         best_in     = rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (item.opcode == OP_TICK) begin
                  state_in = ST_SCAN;
                  cnt_in   = '0;
                  found_in = 1'b0;
               end else if (load_hit) begin
                  pend_in[load_idx] = (item.burst != '0);
               end
            end
         end
         ST_SCAN: begin
            cand_vld_in = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
               time_in  = time_next;
               if (finish) begin
                  pend_in[best_idx_ff] = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         cand_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         pend_ff     <= '0;
         time_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         cand_vld_ff <= cand_vld_in;
         found_ff    <= found_in;
         pend_ff     <= pend_in;
         time_ff     <= time_in;
      end
   end

   // Scan payload, no reset needed
   always_ff @(posedge clock) begin
      cand_idx_ff <= cand_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/preemptive_priority_scheduler_core.sv
`default_nettype none

// Channel  Direction  tdata (low bit up)                         tuser
// req_     in         slot[3:0] arrival[19:4] burst[35:20]        opcode
//                     prio[43:36], zero fill to 48
// rsp_     out        time_after[15:0] granted_slot[19:16]        idle
//                     left_after[35:20] finished[36], zero fill to 40
//
// A load item gives no result.
// A tick item makes one memory read per slot through the single read port of
// the slot memory, then passes one compare stage and one write-back.
// Synchronous active-high reset clears the pending flags and the time; the
// slot memory holds no reset value since only pending slots are ever used.
// The result register frees the next item unless a held result still waits on rsp_tready.

module preemptive_priority_scheduler_core #(
   parameter int unsigned SLOTS     = 16,
   parameter int unsigned TIME_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [pps_pkg::REQ_DATA_W-1:0]    req_tdata,  // slot, arrival, burst, prio
   input  wire logic                              req_tuser,  // opcode
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [pps_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // time_after, granted_slot,
                                                              // left_after, finished
   output logic                                   rsp_tuser   // idle
);
   import pps_pkg::*;

   req_item_type item;
   logic         res_valid;
   logic         res_ready;
   rsp_item_type res;
   logic         out_vld_ff, out_vld_in;
   rsp_item_type out_ff;

   // Unpack the input item
   always_comb begin
      item.opcode  = opcode_type'(req_tuser);
      item.slot    = req_tdata[3:0];
      item.arrival = req_tdata[19:4];
      item.burst   = req_tdata[35:20];
      item.prio    = req_tdata[43:36];
   end

   pps_ctrl #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Output register
   assign res_ready = !out_vld_ff || rsp_tready;

   always_comb begin
      out_vld_in = out_vld_ff;
      if (res_valid && res_ready) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   // Pack the result item
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.idle;
   assign rsp_tdata  = {3'b000, out_ff.finished, out_ff.left_after,
                        out_ff.granted_slot, out_ff.time_after};

endmodule

`default_nettype wire

>>> tb/preemptive_priority_scheduler_core_tb.sv
`default_nettype none

module preemptive_priority_scheduler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pps_pkg::*;

   localparam int unsigned SLOT_COUNT      = 16;
   localparam int unsigned CLK_PERIOD      = 10;
   localparam int unsigned RESET_CYCLES    = 11;
   localparam int unsigned RANDOM_ITEMS    = 1800;
   localparam int unsigned PRESSURE_ITEMS  = 40;
   localparam int unsigned PRESSURE_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT  = 5000;
   localparam int unsigned END_PAUSE       = 3 * (SLOT_COUNT + 3);
   localparam logic [TOUT_W-1:0] TIME_LIMIT = '1;

   // DUT ports; the inputs driven here are known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // slot, arrival, burst, prio
   logic                  req_tuser  = OP_LOAD;  // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // time_after, granted_slot, left_after, finished
   logic                  rsp_tuser;  // idle

   // Scheduler state as the testbench tracks it
   logic [ARR_W-1:0]   sched_arrival [SLOT_COUNT];
   logic [BURST_W-1:0] sched_left    [SLOT_COUNT];
   logic [PRIO_W-1:0]  sched_prio    [SLOT_COUNT];
   logic               sched_pending [SLOT_COUNT];
   logic [TOUT_W-1:0]  sched_now;

   rsp_item_type expected_grants[$];

   // Run controls: sender gaps for the stimulus, stall request shared with the receiver
   bit gaps_on       = 1'b1;
   bit stall_request = 1'b0;

   int unsigned n_errors   = 0;
   int unsigned n_checked  = 0;
   int unsigned n_loads    = 0;
   int unsigned n_ticks    = 0;
   int unsigned n_idle     = 0;
   int unsigned n_finished = 0;
   int unsigned idle_cycles = 0;

   preemptive_priority_scheduler_core #(
      .SLOTS     (SLOT_COUNT),
      .TIME_BITS (TOUT_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one accepted item to the tracked schedule; ticks queue their grant
   task automatic schedule_item(input opcode_type op, input logic [SLOT_FIELD_W-1:0] slot,
                                input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                                input logic [PRIO_W-1:0] prio);
      rsp_item_type grant;
      int best;
      logic [PRIO_W-1:0] best_prio;
      if (op == OP_LOAD) begin
         n_loads++;
         sched_arrival[slot] = arr;
         sched_left[slot]    = burst;
         sched_prio[slot]    = prio;
         sched_pending[slot] = (burst != 0);
         return;
      end
      n_ticks++;
      best      = -1;
      best_prio = '0;
      // highest priority among arrived slots, lowest slot wins a tie
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (sched_pending[i] && sched_arrival[i] <= sched_now) begin
            if (best < 0 || sched_prio[i] > best_prio) begin
               best      = i;
               best_prio = sched_prio[i];
            end
         end
      end
      if (sched_now != TIME_LIMIT) sched_now++;
      grant            = '0;
      grant.time_after = sched_now;
      if (best < 0) begin
         grant.idle = 1'b1;
         n_idle++;
      end else begin
         if (sched_left[best] != 0) sched_left[best]--;
         grant.granted_slot = best[SLOT_FIELD_W-1:0];
         grant.left_after   = sched_left[best];
         if (sched_left[best] == 0) begin
            sched_pending[best] = 1'b0;
            grant.finished      = 1'b1;
            n_finished++;
         end
      end
      expected_grants.push_back(grant);
   endtask

   function automatic int pick_gap();
      int unsigned r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one item from a falling edge; valid stays high across back-to-back items
   task automatic send_item(input opcode_type op, input logic [SLOT_FIELD_W-1:0] slot,
                            input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                            input logic [PRIO_W-1:0] prio);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, prio, burst, arr, slot};
      do @(posedge clock); while (!req_tready);
      schedule_item(op, slot, arr, burst, prio);
   endtask

   task automatic load(input int unsigned slot, input int unsigned arr,
                       input int unsigned burst, input int unsigned prio);
      send_item(OP_LOAD, slot[SLOT_FIELD_W-1:0], arr[ARR_W-1:0], burst[BURST_W-1:0],
                prio[PRIO_W-1:0]);
   endtask

   // Tick payload is ignored by the block, so it carries noise
   task automatic tick();
      send_item(OP_TICK, SLOT_FIELD_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
                PRIO_W'($urandom));
   endtask

   task automatic send_random_load();
      int unsigned r;
      int unsigned a;
      int unsigned arr;
      int unsigned burst;
      int unsigned prio;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         // mostly just about to arrive, so the slot competes soon
         a   = sched_now + $urandom_range(0, 12);
         arr = (a > TIME_LIMIT) ? TIME_LIMIT : a;
      end else if (r < 85) begin
         arr = $urandom_range(0, 65535);
      end else begin
         arr = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65)      burst = $urandom_range(1, 6);
      else if (r < 75) burst = 0;
      else if (r < 87) burst = $urandom_range(7, 40);
      else             burst = $urandom_range(0, 65535);
      // narrow priorities make ties common
      prio = ($urandom_range(0, 99) < 55) ? $urandom_range(0, 7) : $urandom_range(0, 255);
      load($urandom_range(0, SLOT_COUNT - 1), arr, burst, prio);
   endtask

   task automatic test_idle_after_reset();
      tick();
   endtask

   task automatic test_priority_and_ties();
      load(0, 0, 0, 255);   // zero burst: never pending
      load(15, 0, 2, 255);
      load(3, 0, 1, 0);
      load(5, 0, 1, 9);
      load(9, 0, 1, 9);     // same priority as slot 5, slot 5 goes first
      repeat (5) tick();
   endtask

   task automatic test_future_arrival_preemption();
      load(4, 0, 3, 1);
      load(11, sched_now + 2, 1, 200);  // arrives mid-run and preempts slot 4
      repeat (4) tick();
   endtask

   task automatic test_field_extremes();
      load(12, 65535, 65535, 255);  // pending but far in the future
      tick();
      load(12, 0, 65535, 0);
      tick();
      load(12, 0, 0, 255);          // overwrite with zero burst clears the slot
      tick();
   endtask

   task automatic test_random_traffic(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         // alternate stretches with and without sender gaps
         if (n % 150 == 0) gaps_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 99) < 45) send_random_load();
         else                            tick();
      end
      gaps_on = 1'b1;
   endtask

   // Receiver holds off while the sender streams, so the input backs up
   task automatic test_backpressure();
      gaps_on       = 1'b0;
      stall_request = 1'b1;
      for (int unsigned n = 0; n < PRESSURE_ITEMS; n++) begin
         if ($urandom_range(0, 99) < 85) tick();
         else                            send_random_load();
      end
      gaps_on = 1'b1;
   endtask

   // Result receiver: random stalls, calm stretches, and the long hold-off on request
   initial begin : rsp_drive
      int unsigned hold;
      int unsigned phase_left;
      bit calm;
      calm       = 1'b0;
      phase_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (phase_left == 0) begin
            calm       = ($urandom_range(0, 2) == 0);
            phase_left = $urandom_range(100, 400);
         end
         phase_left--;
         if (stall_request) begin
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(negedge clock);
            stall_request = 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else begin
            hold = $urandom_range(0, 99);
            if (hold < 70) begin
               rsp_tready <= 1'b1;
               @(negedge clock);
            end else begin
               hold = (hold < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
               rsp_tready <= 1'b0;
               repeat (hold) @(negedge clock);
            end
         end
      end
   end

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         n_errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
   endtask

   // Compare each result with the oldest queued grant
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_grants.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_grants.pop_front();
            n_checked++;
            check_field("time_after", 32'(want.time_after), 32'(rsp_tdata[15:0]));
            check_field("granted_slot", 32'(want.granted_slot), 32'(rsp_tdata[19:16]));
            check_field("idle", 32'(want.idle), 32'(rsp_tuser));
            check_field("left_after", 32'(want.left_after), 32'(rsp_tdata[35:20]));
            check_field("finished", 32'(want.finished), 32'(rsp_tdata[36]));
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 == WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_grants.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         sched_arrival[i] = '0;
         sched_left[i]    = '0;
         sched_prio[i]    = '0;
         sched_pending[i] = 1'b0;
      end
      sched_now = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_after_reset();
      test_priority_and_ties();
      test_future_arrival_preemption();
      test_field_extremes();
      test_random_traffic(RANDOM_ITEMS / 2);
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2 - PRESSURE_ITEMS);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0) @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);

      $display("Covered %0d loads and %0d ticks: %0d idle ticks, %0d completions, time at %0d.",
               n_loads, n_ticks, n_idle, n_finished, sched_now);
      $display("Compared %0d results, %0d mismatches.", n_checked, n_errors);
      if (n_errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
